// ===== rtl/core/medh_pkg.sv =====
// Package for the mesh edge dedup hash core: sizes, FSM state type,
// and the controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package medh_pkg;
    localparam int VertexBits  = 20;
    localparam int Buckets     = 1024;
    localparam int BucketBits  = 10;
    localparam int MaxEdges    = 4096;
    localparam int IdxBits     = 13;
    localparam int AddrBits    = 12;
    localparam int EdgeOutBits = 14;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HEAD_RD,
        ST_HEAD_WAIT,
        ST_CHAIN_RD,
        ST_CHAIN_WAIT,
        ST_CHECK,
        ST_NEXT,
        ST_DONE
    } medh_state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;   // write zero to the bucket head at the sweep pointer
        logic load_item;    // capture the triangle, reset the side counter
        logic head_read;    // read bucket head of the target vertex
        logic entry_read;   // follow the link of the edge entry at the cursor
        logic take_found;   // record the reversed edge at the cursor
        logic take_create;  // store a new edge or record store full
        logic next_side;    // move to the next edge of the triangle
        logic out_load;     // present the result item
        logic out_clear;    // result item taken
    } medh_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;
        logic cursor_zero;
        logic match;
        logic last_side;
        logic out_busy;
    } medh_sts_t;
endpackage

// ===== rtl/core/medh_datapath.sv =====
// Datapath for the mesh edge dedup hash core: bucket head memory,
// edge store memories, edge counter and result register. Uses medh_pkg.
`timescale 1ns / 1ps
module medh_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  medh_pkg::medh_cmd_t                   cmd,
    output medh_pkg::medh_sts_t                   sts,
    input  logic [medh_pkg::VertexBits-1:0]       s_vertex_a,
    input  logic [medh_pkg::VertexBits-1:0]       s_vertex_b,
    input  logic [medh_pkg::VertexBits-1:0]       s_vertex_c,
    output logic                                  m_valid,
    output logic signed [medh_pkg::EdgeOutBits-1:0] m_edge_ab,
    output logic signed [medh_pkg::EdgeOutBits-1:0] m_edge_bc,
    output logic signed [medh_pkg::EdgeOutBits-1:0] m_edge_ca,
    output logic                                  m_store_full,
    output logic [medh_pkg::IdxBits-1:0]          m_edges_stored
);
    localparam int VB = medh_pkg::VertexBits;
    localparam int IB = medh_pkg::IdxBits;
    localparam int BB = medh_pkg::BucketBits;
    localparam int AB = medh_pkg::AddrBits;
    localparam int EB = medh_pkg::EdgeOutBits;

    // Memories: heads indexed by bucket, edge entries by index minus one
    logic [IB-1:0] head_mem [medh_pkg::Buckets];
    logic [VB-1:0] from_mem [medh_pkg::MaxEdges];
    logic [VB-1:0] to_mem   [medh_pkg::MaxEdges];
    logic [IB-1:0] link_mem [medh_pkg::MaxEdges];

    logic [VB-1:0] va_reg, vb_reg, vc_reg;
    logic [1:0]    side_reg;
    logic [BB-1:0] clr_ptr_reg;
    logic          clr_done_reg;
    logic [IB-1:0] cursor_reg;
    logic [IB-1:0] head_rd_reg;
    logic [VB-1:0] from_rd_reg, to_rd_reg;
    logic [IB-1:0] link_rd_reg;
    logic [IB-1:0] total_reg;
    logic [EB-1:0] res_reg [3];
    logic          full_reg;
    logic          m_valid_reg;

    // Current edge (p,q)
    logic [VB-1:0] p, q;
    always_comb begin
        unique case (side_reg)
            2'd0:    begin p = va_reg; q = vb_reg; end
            2'd1:    begin p = vb_reg; q = vc_reg; end
            default: begin p = vc_reg; q = va_reg; end
        endcase
    end

    logic is_full;
    assign is_full = (total_reg == IB'(medh_pkg::MaxEdges));

    // Link for a new edge: head of bucket p, read during the walk setup
    logic [IB-1:0] head_mem_wr_link;
    logic [IB-1:0] plink_reg;
    logic [IB-1:0] cursor_m1;
    assign cursor_m1 = cursor_reg - IB'(1);
    assign head_mem_wr_link = plink_reg;
    always_ff @(posedge aclk) begin
        plink_reg <= head_mem[p[BB-1:0]];
    end

    // Head memory: clear sweep, lookup read, insertion write
    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            head_mem[clr_ptr_reg] <= '0;
        end else if (cmd.take_create && !is_full) begin
            head_mem[p[BB-1:0]] <= total_reg + IB'(1);
        end
        head_rd_reg <= head_mem[q[BB-1:0]];
    end

    // Edge store: write new entry, read entry at cursor
    always_ff @(posedge aclk) begin
        if (cmd.take_create && !is_full) begin
            from_mem[total_reg[AB-1:0]] <= p;
            to_mem[total_reg[AB-1:0]]   <= q;
            link_mem[total_reg[AB-1:0]] <= head_mem_wr_link;
        end
        from_rd_reg <= from_mem[cursor_m1[AB-1:0]];
        to_rd_reg   <= to_mem[cursor_m1[AB-1:0]];
        link_rd_reg <= link_mem[cursor_m1[AB-1:0]];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_ptr_reg  <= '0;
            clr_done_reg <= 1'b0;
            total_reg    <= '0;
            m_valid_reg  <= 1'b0;
            side_reg     <= '0;
            cursor_reg   <= '0;
        end else begin
            if (cmd.clear_step) begin
                clr_ptr_reg <= clr_ptr_reg + BB'(1);
                if (clr_ptr_reg == BB'(medh_pkg::Buckets - 1)) clr_done_reg <= 1'b1;
            end
            if (cmd.load_item) side_reg <= '0;
            else if (cmd.next_side) side_reg <= side_reg + 2'd1;
            if (cmd.head_read) cursor_reg <= head_rd_reg;
            else if (cmd.entry_read) cursor_reg <= link_rd_reg;
            if (cmd.take_create && !is_full) total_reg <= total_reg + IB'(1);
            if (cmd.out_load) m_valid_reg <= 1'b1;
            else if (cmd.out_clear) m_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            va_reg   <= s_vertex_a;
            vb_reg   <= s_vertex_b;
            vc_reg   <= s_vertex_c;
            full_reg <= 1'b0;
        end
        if (cmd.take_found) begin
            res_reg[side_reg] <= EB'(0) - EB'(cursor_reg);
        end else if (cmd.take_create) begin
            if (is_full) begin
                res_reg[side_reg] <= '0;
                full_reg <= 1'b1;
            end else begin
                res_reg[side_reg] <= EB'(total_reg + IB'(1));
            end
        end
        if (cmd.out_load) begin
            m_edge_ab      <= res_reg[0];
            m_edge_bc      <= res_reg[1];
            m_edge_ca      <= res_reg[2];
            m_store_full   <= full_reg;
            m_edges_stored <= total_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign sts.clear_done  = clr_done_reg;
    assign sts.cursor_zero = (cursor_reg == '0);
    assign sts.match       = (from_rd_reg == q) && (to_rd_reg == p);
    assign sts.last_side   = (side_reg == 2'd2);
    assign sts.out_busy    = m_valid_reg;

    // Edge count never exceeds the store size
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= IB'(medh_pkg::MaxEdges)) else $error("edge count overflow");
    // A full store never grows
    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        is_full |=> is_full) else $error("full store changed");
    // Side counter stays within a triangle
    a_side: assert property (@(posedge aclk) disable iff (!aresetn)
        side_reg != 2'd3) else $error("side counter out of range");
endmodule

// ===== rtl/core/medh_ctrl.sv =====
// Controller for the mesh edge dedup hash core: clear sweep, then per edge
// head read, chain walk and insert. Uses medh_pkg.
`timescale 1ns / 1ps
module medh_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                m_ready,
    input  medh_pkg::medh_sts_t sts,
    output medh_pkg::medh_cmd_t cmd
);
    medh_pkg::medh_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= medh_pkg::ST_CLEAR;
        else          state_reg <= state_next;
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        cmd.out_clear = sts.out_busy && m_ready;
        unique case (state_reg)
            medh_pkg::ST_CLEAR: begin
                cmd.clear_step = !sts.clear_done;
                if (sts.clear_done) state_next = medh_pkg::ST_IDLE;
            end
            medh_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next = medh_pkg::ST_HEAD_RD;
                end
            end
            // heads read registered in this cycle
            medh_pkg::ST_HEAD_RD:   state_next = medh_pkg::ST_HEAD_WAIT;
            medh_pkg::ST_HEAD_WAIT: begin
                cmd.head_read = 1'b1;
                state_next = medh_pkg::ST_CHAIN_RD;
            end
            medh_pkg::ST_CHAIN_RD: begin
                if (sts.cursor_zero) begin
                    cmd.take_create = 1'b1;
                    state_next = medh_pkg::ST_NEXT;
                end else begin
                    state_next = medh_pkg::ST_CHAIN_WAIT;
                end
            end
            medh_pkg::ST_CHAIN_WAIT: state_next = medh_pkg::ST_CHECK;
            medh_pkg::ST_CHECK: begin
                if (sts.match) begin
                    cmd.take_found = 1'b1;
                    state_next = medh_pkg::ST_NEXT;
                end else begin
                    cmd.entry_read = 1'b1;
                    state_next = medh_pkg::ST_CHAIN_RD;
                end
            end
            medh_pkg::ST_NEXT: begin
                if (sts.last_side) begin
                    state_next = medh_pkg::ST_DONE;
                end else begin
                    cmd.next_side = 1'b1;
                    state_next = medh_pkg::ST_HEAD_RD;
                end
            end
            medh_pkg::ST_DONE: begin
                if (!sts.out_busy || m_ready) begin
                    cmd.out_load = 1'b1;
                    cmd.out_clear = 1'b0;
                    state_next = medh_pkg::ST_IDLE;
                end
            end
            default: state_next = medh_pkg::ST_CLEAR;
        endcase
    end

    // Items are taken only when idle
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == medh_pkg::ST_IDLE) else $error("ready outside idle");
    // A result is never loaded over an untaken one
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!sts.out_busy || m_ready)) else $error("result overwritten");
    // Found and create never in the same cycle
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.take_found && cmd.take_create)) else $error("found and create together");
endmodule

// ===== rtl/core/mesh_edge_dedup_hash_core.sv =====
// Top level of the mesh edge dedup hash core: joins controller and datapath.
// Depends on medh_pkg, medh_ctrl and medh_datapath.
// Usage:
//   Input channel s_valid/s_ready carries one triangle (three 20-bit vertex
//   indices). Result channel m_valid/m_ready carries three signed edge
//   indices, a store-full flag and the stored edge count.
//   Each edge reads the bucket head of its reversed edge, then walks the
//   chain entry by entry through the edge store (CHAIN_RD, CHAIN_WAIT,
//   CHECK per entry); the chain walk sets the rate. One triangle at a time.
//   The result register holds a result while the receiver stalls; the next
//   triangle is accepted and processed meanwhile, waiting only at the end.
//   After reset a clearing pass zeroes all 1024 bucket heads; s_ready
//   stays low during it. Reset is synchronous, active low.
`timescale 1ns / 1ps
module mesh_edge_dedup_hash_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [medh_pkg::VertexBits-1:0]       s_vertex_a,
    input  logic [medh_pkg::VertexBits-1:0]       s_vertex_b,
    input  logic [medh_pkg::VertexBits-1:0]       s_vertex_c,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [medh_pkg::EdgeOutBits-1:0] m_edge_ab,
    output logic signed [medh_pkg::EdgeOutBits-1:0] m_edge_bc,
    output logic signed [medh_pkg::EdgeOutBits-1:0] m_edge_ca,
    output logic                                  m_store_full,
    output logic [medh_pkg::IdxBits-1:0]          m_edges_stored
);
    medh_pkg::medh_cmd_t cmd;
    medh_pkg::medh_sts_t sts;

    medh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    medh_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_vertex_a     (s_vertex_a),
        .s_vertex_b     (s_vertex_b),
        .s_vertex_c     (s_vertex_c),
        .m_valid        (m_valid),
        .m_edge_ab      (m_edge_ab),
        .m_edge_bc      (m_edge_bc),
        .m_edge_ca      (m_edge_ca),
        .m_store_full   (m_store_full),
        .m_edges_stored (m_edges_stored)
    );
endmodule
